@@ src/bpc_pkg.sv @@
// ----------------------------------------------------------------------------
// bpc_pkg
// types, constants and helper functions for barometric compensation
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_AC1_AC2 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AC3_AC4 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AC5_AC6 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_B1_B2   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MC_MD   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OSS     = 3'd5;

  localparam logic [1:0]  OSS_RESET     = 2'd3;
  localparam logic [31:0] B6_OFFSET     = 32'd4000;
  localparam logic [31:0] POLY_SQ       = 32'd3038;
  localparam logic [31:0] POLY_LIN      = 32'hFFFF_E343; // -7357
  localparam logic [31:0] POLY_BIAS     = 32'd3791;
  localparam logic [31:0] SCALE_PA      = 32'd50000;
  localparam logic [31:0] B4_BIAS       = 32'd32768;
  localparam logic [31:0] SIGN_BIT      = 32'h8000_0000;
  localparam int unsigned DIV_W         = 32;

  typedef struct packed {
    logic signed [15:0] raw_temperature;
    logic [23:0]        raw_pressure_word;
  } in_t;

  typedef struct packed {
    logic signed [15:0] temperature_tenths;
    logic signed [31:0] pressure_pa;
    logic               fault;
  } out_t;

  typedef struct packed {
    logic [15:0] ac1;
    logic [15:0] ac2;
    logic [15:0] ac3;
    logic [15:0] ac4;
    logic [15:0] ac5;
    logic [15:0] ac6;
    logic [15:0] b1;
    logic [15:0] b2;
    logic [15:0] mc;
    logic [15:0] md;
    logic [1:0]  oss;
  } cal_t;

  // front end to back end
  typedef struct packed {
    logic [31:0] b5;
    logic [23:0] raw;
    logic        fault;
  } temp_t;

  // side data through the temperature divider
  typedef struct packed {
    logic [31:0] x1;
    logic [23:0] raw;
    logic        neg;
    logic        fault;
  } tside_t;

  // side data through the pressure divider
  typedef struct packed {
    logic [15:0] t;
    logic        dbl;
    logic        fault;
  } pside_t;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] s);
    return 32'($signed(v) >>> s);
  endfunction

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? 32'(32'd0 - v) : v;
  endfunction

endpackage

@@ src/bpc_div.sv @@
// ----------------------------------------------------------------------------
// bpc_div
// pipelined unsigned restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module bpc_div #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [31:0]       num,
  input  logic [31:0]       den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [31:0]       quo,
  output logic [SIDE_W-1:0] side_out
);
  import bpc_pkg::*;

  logic              vld  [0:DIV_W];
  logic [31:0]       nreg [0:DIV_W];
  logic [31:0]       dreg [0:DIV_W];
  logic [31:0]       rreg [0:DIV_W];
  logic [31:0]       qreg [0:DIV_W];
  logic [SIDE_W-1:0] sreg [0:DIV_W];

  assign vld[0]  = in_valid;
  assign nreg[0] = num;
  assign dreg[0] = den;
  assign rreg[0] = '0;
  assign qreg[0] = '0;
  assign sreg[0] = side_in;

  for (genvar i = 0; i < DIV_W; i++) begin : g_stage
    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;

    assign trial = {rreg[i], nreg[i][31]};
    assign diff  = trial - {1'b0, dreg[i]};
    assign ge    = trial >= {1'b0, dreg[i]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
      nreg[i+1] <= {nreg[i][30:0], 1'b0};
      dreg[i+1] <= dreg[i];
      rreg[i+1] <= ge ? diff[31:0] : trial[31:0];
      qreg[i+1] <= {qreg[i][30:0], ge};
      sreg[i+1] <= sreg[i];
    end
  end

  assign out_valid = vld[DIV_W];
  assign quo       = qreg[DIV_W];
  assign side_out  = sreg[DIV_W];

endmodule

@@ src/bpc_front.sv @@
// ----------------------------------------------------------------------------
// bpc_front
// temperature path: x1, signed divide of mc by x1 plus md, b5
// ----------------------------------------------------------------------------
module bpc_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  bpc_pkg::in_t  sample,
  input  bpc_pkg::cal_t cal,
  output logic          out_valid,
  output bpc_pkg::temp_t out_temp
);
  import bpc_pkg::*;

  logic        v1, v2, v3, v4;
  logic [31:0] ut1;
  logic [23:0] raw1, raw2;
  logic [31:0] x1_2, d2;
  logic [31:0] nm3, dm3;
  tside_t      side3, side_o;
  logic        dv_valid;
  logic [31:0] dv_quo;
  logic [31:0] x2;
  temp_t       t4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= dv_valid;
    end
    ut1  <= sx16(sample.raw_temperature);
    raw1 <= sample.raw_pressure_word;
    x1_2 <= asr32(32'((ut1 - {16'd0, cal.ac6}) * {16'd0, cal.ac5}), 5'd15);
    d2   <= asr32(32'((ut1 - {16'd0, cal.ac6}) * {16'd0, cal.ac5}), 5'd15) + sx16(cal.md);
    raw2 <= raw1;
    nm3  <= mag32({{5{cal.mc[15]}}, cal.mc, 11'd0});
    dm3  <= mag32(d2);
    side3.x1    <= x1_2;
    side3.raw   <= raw2;
    side3.neg   <= cal.mc[15] ^ d2[31];
    side3.fault <= d2 == 32'd0;
    t4 <= '{b5: side_o.x1 + x2, raw: side_o.raw, fault: side_o.fault};
  end

  bpc_div #(.SIDE_W($bits(tside_t))) u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v3),
    .num      (nm3),
    .den      (dm3),
    .side_in  (side3),
    .out_valid(dv_valid),
    .quo      (dv_quo),
    .side_out (side_o)
  );

  assign x2        = side_o.neg ? 32'(32'd0 - dv_quo) : dv_quo;
  assign out_valid = v4;
  assign out_temp  = t4;

endmodule

@@ src/bpc_back.sv @@
// ----------------------------------------------------------------------------
// bpc_back
// pressure path: b3, b4, b7, unsigned divide and polynomial correction
// ----------------------------------------------------------------------------
module bpc_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  bpc_pkg::temp_t in_temp,
  input  bpc_pkg::cal_t  cal,
  output logic           out_valid,
  output bpc_pkg::out_t  result
);
  import bpc_pkg::*;

  logic        v1, v2, v3, v4, v5, v6, v8, v9, v10;
  logic [15:0] t1, t2, t3, t4, t5, t6;
  logic [23:0] raw1, raw2, raw3, raw4;
  logic        f1, f2, f3, f4, f5, f6;
  logic [31:0] b6_1;
  logic [31:0] sqp2, a2_2, a3_2;
  logic [31:0] sq;
  logic [31:0] mb2_3, mb1_3, a2_3, a3_3;
  logic [31:0] b3_4, s4;
  logic [31:0] b4_5, diff5;
  logic [31:0] b7_6, b4_6;
  logic [31:0] tt;
  logic [15:0] tsat;
  logic [31:0] x3a, x1b, x2b, x3b;
  logic [31:0] b4full;
  pside_t      pside, pside_o;
  logic        dv_valid;
  logic [31:0] dv_quo, p;
  logic [31:0] p8, pdiv, m7_8, psq8;
  logic [15:0] t8, t9;
  logic        f8, f9;
  logic [31:0] p9, m7_9, m3_9;
  logic [31:0] x1c, x2c, pfin;
  out_t        res;

  assign tt   = asr32(in_temp.b5 + 32'd8, 5'd4);
  assign tsat = ($signed(tt) > 32'sd32767)  ? 16'h7FFF :
                ($signed(tt) < -32'sd32768) ? 16'h8000 : tt[15:0];

  assign sq  = asr32(sqp2, 5'd12);
  assign x3a = asr32(mb2_3, 5'd11) + asr32(a2_3, 5'd11);
  assign x1b = asr32(a3_3, 5'd13);
  assign x2b = asr32(mb1_3, 5'd16);
  assign x3b = asr32(x1b + x2b + 32'd2, 5'd2);
  assign b4full = 32'({16'd0, cal.ac4} * s4);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
      v6 <= 1'b0; v8 <= 1'b0; v9 <= 1'b0; v10 <= 1'b0;
    end else begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4;
      v6 <= v5; v8 <= dv_valid; v9 <= v8; v10 <= v9;
    end
    // b6 and saturated temperature
    b6_1 <= in_temp.b5 - B6_OFFSET;
    t1   <= tsat;
    raw1 <= in_temp.raw;
    f1   <= in_temp.fault;
    // products on b6
    sqp2 <= 32'(b6_1 * b6_1);
    a2_2 <= 32'(sx16(cal.ac2) * b6_1);
    a3_2 <= 32'(sx16(cal.ac3) * b6_1);
    t2 <= t1; raw2 <= raw1; f2 <= f1;
    // products on b6 squared
    mb2_3 <= 32'(sx16(cal.b2) * sq);
    mb1_3 <= 32'(sx16(cal.b1) * sq);
    a2_3 <= a2_2; a3_3 <= a3_2;
    t3 <= t2; raw3 <= raw2; f3 <= f2;
    // b3 and b4 operand
    b3_4 <= asr32(32'(((sx16(cal.ac1) << 2) + x3a) << cal.oss) + 32'd2, 5'd2);
    s4   <= x3b + B4_BIAS;
    t4 <= t3; raw4 <= raw3; f4 <= f3;
    // b4 and scaled pressure difference
    b4_5  <= {15'd0, b4full[31:15]};
    diff5 <= ({8'd0, raw4} >> (4'd8 - {2'd0, cal.oss})) - b3_4;
    t5 <= t4; f5 <= f4;
    // b7
    b7_6 <= 32'(diff5 * (SCALE_PA >> cal.oss));
    b4_6 <= b4_5;
    t6 <= t5;
    f6 <= f5 | (b4_5 == 32'd0);
    // after divide: p and correction products
    p8   <= p;
    psq8 <= 32'(pdiv * pdiv);
    m7_8 <= 32'(POLY_LIN * p);
    t8 <= pside_o.t; f8 <= pside_o.fault;
    // square term
    m3_9 <= 32'(psq8 * POLY_SQ);
    p9 <= p8; m7_9 <= m7_8; t9 <= t8; f9 <= f8;
    // final
    res <= f9 ? '{temperature_tenths: '0, pressure_pa: '0, fault: 1'b1}
              : '{temperature_tenths: t9, pressure_pa: pfin, fault: 1'b0};
  end

  assign pside = '{t: t6, dbl: ~b7_6[31], fault: f6};

  bpc_div #(.SIDE_W($bits(pside_t))) u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v6),
    .num      (b7_6[31] ? b7_6 : {b7_6[30:0], 1'b0}),
    .den      (b4_6),
    .side_in  (pside),
    .out_valid(dv_valid),
    .quo      (dv_quo),
    .side_out (pside_o)
  );

  assign p    = pside_o.dbl ? dv_quo : {dv_quo[30:0], 1'b0};
  assign pdiv = asr32(p, 5'd8);
  assign x1c  = asr32(m3_9, 5'd16);
  assign x2c  = asr32(m7_9, 5'd16);
  assign pfin = p9 + asr32(x1c + x2c + POLY_BIAS, 5'd4);

  assign out_valid = v10;
  assign result    = res;

endmodule

@@ src/barometric_pressure_compensation.sv @@
// ----------------------------------------------------------------------------
// barometric_pressure_compensation
// integer temperature and pressure compensation, fully pipelined
// ----------------------------------------------------------------------------
// channel  | handshake            | payload
// sample   | start, busy          | sample (in_t)
// result   | done (one cycle)     | result (out_t)
// config   | cfg_valid, cfg_ready | cfg_index, cfg_data
//
// one item enters per cycle while busy is low; the path runs through the two
// 32-stage divider pipelines plus the multiply stages around them
// synchronous reset clears all valid bits and loads calibration defaults
// busy is high during reset and in the cycle after it; there are no stalls
// ----------------------------------------------------------------------------
module barometric_pressure_compensation (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  bpc_pkg::in_t                     sample,
  output logic                             done,
  output bpc_pkg::out_t                    result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                      cfg_data
);
  import bpc_pkg::*;

  logic [31:0] ac1_ac2, ac3_ac4, ac5_ac6, b1_b2, mc_md;
  logic [1:0]  oss;
  logic        busy_r;
  cal_t        cal;
  logic        fv;
  temp_t       ft;

  always_ff @(posedge clk) begin
    if (rst) begin
      ac1_ac2 <= '0;
      ac3_ac4 <= '0;
      ac5_ac6 <= '0;
      b1_b2   <= '0;
      mc_md   <= '0;
      oss     <= OSS_RESET;
      busy_r  <= 1'b1;
    end else begin
      busy_r <= 1'b0;
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_AC1_AC2: ac1_ac2 <= cfg_data;
          CFG_AC3_AC4: ac3_ac4 <= cfg_data;
          CFG_AC5_AC6: ac5_ac6 <= cfg_data;
          CFG_B1_B2:   b1_b2   <= cfg_data;
          CFG_MC_MD:   mc_md   <= cfg_data;
          CFG_OSS:     oss     <= cfg_data[1:0];
          default: ;
        endcase
      end
    end
  end

  assign busy      = busy_r;
  assign cfg_ready = 1'b1;

  assign cal = '{ac1: ac1_ac2[31:16], ac2: ac1_ac2[15:0],
                 ac3: ac3_ac4[31:16], ac4: ac3_ac4[15:0],
                 ac5: ac5_ac6[31:16], ac6: ac5_ac6[15:0],
                 b1: b1_b2[31:16],    b2: b1_b2[15:0],
                 mc: mc_md[31:16],    md: mc_md[15:0],
                 oss: oss};

  bpc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start & ~busy_r),
    .sample   (sample),
    .cal      (cal),
    .out_valid(fv),
    .out_temp (ft)
  );

  bpc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (fv),
    .in_temp  (ft),
    .cal      (cal),
    .out_valid(done),
    .result   (result)
  );

  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.fault |-> result.pressure_pa == 0 && result.temperature_tenths == 0)
    else $error("faulted item carries non-zero values");

  a_reset_flush: assert property (@(posedge clk) rst |=> !done && busy)
    else $error("pipeline not flushed by reset");

  a_oss_range: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_index == CFG_OSS |=> oss == $past(cfg_data[1:0]))
    else $error("oversampling write lost");

endmodule
